FILE: design/tbc_pkg.sv
// shared types, constants and byte helpers for the 32-bit toy block cipher
package tbc_pkg;

    localparam int NUM_RK       = 32;
    localparam int RK_AW        = $clog2(NUM_RK);
    localparam int NUM_ROUNDS   = 16;
    localparam int GROUP_ROUNDS = 4;
    localparam int NUM_MASH     = NUM_ROUNDS / GROUP_ROUNDS - 1;
    localparam int MASH_STEPS   = 4;
    localparam int WORD_W       = 32;
    localparam int KEY_W        = 64;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_key_bank [NUM_RK];

    typedef enum logic {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } t_action;

    typedef struct packed {
        logic    valid;
        t_action action;
        t_word   blk;
    } t_stage;

    // round key write from the schedule into the mash key memories
    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
        t_word            data;
    } t_key_wr;

    localparam t_word KS_TABLE [NUM_RK] = '{
        32'h6a09e667, 32'hbb67ae84, 32'h3c6ef372, 32'ha54ff539,
        32'h510e527f, 32'h9b05688b, 32'h1f83d9ab, 32'h5be0cd18,
        32'hcbbb9d5c, 32'h629a2929, 32'h91590159, 32'h152fecd8,
        32'h67332667, 32'h8eb44a86, 32'hdb0c2e0c, 32'h47b5481d,
        32'hae5f9156, 32'hcf6c85d2, 32'h2f73477d, 32'h6d1826ca,
        32'h8b43d456, 32'he360b595, 32'h1c456002, 32'h6f196330,
        32'hd94ebeb0, 32'h0cc4a611, 32'h261dc1f2, 32'h5815a7bd,
        32'h70b7ed67, 32'ha1513c68, 32'h44f93635, 32'h720dcdfd
    };

    localparam logic [2:0] ROT_AMT [4] = '{3'd2, 3'd3, 3'd5, 3'd7};

    function automatic logic [7:0] get_byte(input t_word x, input logic [1:0] lane);
        return x[lane*8 +: 8];
    endfunction

    function automatic t_word put_byte(input t_word x, input logic [1:0] lane,
                                       input logic [7:0] v);
        t_word r;
        r = x;
        r[lane*8 +: 8] = v;
        return r;
    endfunction

endpackage

FILE: design/tbc_ram.sv
// generic single write port, single read port ram with registered read
module tbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tbc_key_sched.sv
// key schedule: a ring of round key cells that expands the key and fills the mash memories
module tbc_key_sched (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_key_we,
    input  logic [tbc_pkg::KEY_W-1:0]  i_key,
    output logic                       o_ready,
    output tbc_pkg::t_key_wr           o_kwr,
    output tbc_pkg::t_key_bank         o_round_keys
);

    localparam int AW = tbc_pkg::RK_AW;
    localparam int N  = tbc_pkg::NUM_RK;
    localparam logic [AW-1:0] LAST_FWD = AW'(N - 3);
    localparam logic [AW-1:0] NUM_UPD  = AW'(N - 2);
    localparam logic [AW-1:0] LAST_CNT = AW'(N - 1);

    typedef enum logic [2:0] {
        KS_LOAD,
        KS_FWD,
        KS_BWD,
        KS_COPY,
        KS_DONE
    } t_ks_state;

    t_ks_state                r_state, n_state;
    logic [AW-1:0]            r_cnt, n_cnt;
    logic [tbc_pkg::KEY_W-1:0] r_key;
    tbc_pkg::t_key_bank       r_rk, n_rk;
    tbc_pkg::t_word           w_mix;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rk    = r_rk;
        w_mix   = '0;
        case (r_state)
            KS_LOAD: begin
                n_rk[N-2] = r_key[tbc_pkg::WORD_W-1:0];
                n_rk[N-1] = r_key[tbc_pkg::KEY_W-1:tbc_pkg::WORD_W];
                n_cnt     = '0;
                n_state   = KS_FWD;
            end
            KS_FWD: begin
                // new key enters at the top, the ring moves down one place
                w_mix = r_rk[N-1] ^ r_rk[N-2];
                for (int k = 0; k < N - 1; k++) begin
                    n_rk[k] = r_rk[k+1];
                end
                n_rk[N-1] = tbc_pkg::KS_TABLE[w_mix[AW-1:0]] ^ r_rk[N-1];
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == LAST_FWD) begin
                    n_cnt   = '0;
                    n_state = KS_BWD;
                end
            end
            KS_BWD: begin
                // rotate up; the key passing the update tap sees its two updated successors
                w_mix = r_rk[N-2] ^ r_rk[N-1];
                n_rk[0] = r_rk[N-1];
                for (int k = 1; k < N; k++) begin
                    n_rk[k] = r_rk[k-1];
                end
                if (r_cnt < NUM_UPD) begin
                    n_rk[N-2] = r_rk[N-3] ^ tbc_pkg::KS_TABLE[w_mix[AW-1:0]];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    n_cnt   = '0;
                    n_state = KS_COPY;
                end
            end
            KS_COPY: begin
                for (int k = 0; k < N - 1; k++) begin
                    n_rk[k] = r_rk[k+1];
                end
                n_rk[N-1] = r_rk[0];
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    n_cnt   = '0;
                    n_state = KS_DONE;
                end
            end
            KS_DONE: begin
                n_state = KS_DONE;
            end
            default: begin
                n_state = KS_LOAD;
            end
        endcase
        if (i_key_we) begin
            n_state = KS_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_LOAD;
            r_cnt   <= '0;
            r_key   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_key_we) begin
                r_key <= i_key;
            end
        end
        r_rk <= n_rk;
    end

    assign o_ready      = (r_state == KS_DONE);
    assign o_kwr.en     = (r_state == KS_COPY);
    assign o_kwr.addr   = r_cnt;
    assign o_kwr.data   = r_rk[0];
    assign o_round_keys = r_rk;

endmodule

FILE: design/tbc_round_cell.sv
// one scramble round cell: permutation and byte mixing, forward or inverse
module tbc_round_cell #(
    parameter int POS = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  tbc_pkg::t_stage  i_stage,
    input  tbc_pkg::t_word   i_ka_enc,
    input  tbc_pkg::t_word   i_kb_enc,
    input  tbc_pkg::t_word   i_ka_dec,
    input  tbc_pkg::t_word   i_kb_dec,
    output tbc_pkg::t_stage  o_stage
);

    typedef enum logic [1:0] {
        PM_REV_A,
        PM_BIT,
        PM_NIBBLE,
        PM_REV_B
    } t_perm;

    localparam t_perm ENC_PERM = t_perm'(2'(POS % 4));
    localparam t_perm DEC_PERM = t_perm'(2'(3 - POS % 4));

    function automatic tbc_pkg::t_word permute(input tbc_pkg::t_word x, input t_perm kind,
                                               input logic inverse);
        tbc_pkg::t_word r;
        r = '0;
        case (kind)
            PM_BIT: begin
                for (int k = 0; k < 16; k++) begin
                    if (inverse) begin
                        r[16+k] = x[2*k+1];
                        r[k]    = x[2*k];
                    end else begin
                        r[2*k+1] = x[16+k];
                        r[2*k]   = x[k];
                    end
                end
            end
            PM_NIBBLE: begin
                for (int k = 0; k < 4; k++) begin
                    if (inverse) begin
                        r[16+4*k +: 4] = x[8*k+4 +: 4];
                        r[4*k +: 4]    = x[8*k +: 4];
                    end else begin
                        r[8*k+4 +: 4] = x[16+4*k +: 4];
                        r[8*k +: 4]   = x[4*k +: 4];
                    end
                end
            end
            default: begin
                for (int k = 0; k < 32; k++) begin
                    r[k] = x[31-k];
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] n);
        logic [15:0] t;
        t = {x, x} << n;
        return t[15:8];
    endfunction

    function automatic logic [7:0] rotr8(input logic [7:0] x, input logic [2:0] n);
        logic [15:0] t;
        t = {x, x} >> n;
        return t[7:0];
    endfunction

    function automatic logic [7:0] mix(input tbc_pkg::t_word b, input logic [1:0] i,
                                       input tbc_pkg::t_word ka, input tbc_pkg::t_word kb);
        logic [7:0] p, q, r;
        p = tbc_pkg::get_byte(b, i + 2'd3);
        q = tbc_pkg::get_byte(b, i + 2'd2);
        r = tbc_pkg::get_byte(b, i + 2'd1);
        return (p & q) ^ (~p & r) ^ tbc_pkg::get_byte(ka, i) ^ tbc_pkg::get_byte(kb, i);
    endfunction

    tbc_pkg::t_stage r_stage;
    tbc_pkg::t_word  w_fwd, w_inv;

    // bytes are replaced one after another, each step sees the earlier ones
    always_comb begin
        logic [7:0] m;
        w_fwd = permute(i_stage.blk, ENC_PERM, 1'b0);
        for (int i = 0; i < 4; i++) begin
            m     = mix(w_fwd, 2'(i), i_ka_enc, i_kb_enc);
            w_fwd = tbc_pkg::put_byte(w_fwd, 2'(i),
                        rotl8(tbc_pkg::get_byte(w_fwd, 2'(i)) ^ m, tbc_pkg::ROT_AMT[i]));
        end
        w_inv = i_stage.blk;
        for (int i = 3; i >= 0; i--) begin
            m     = mix(w_inv, 2'(i), i_ka_dec, i_kb_dec);
            w_inv = tbc_pkg::put_byte(w_inv, 2'(i),
                        rotr8(tbc_pkg::get_byte(w_inv, 2'(i)), tbc_pkg::ROT_AMT[i]) ^ m);
        end
        w_inv = permute(w_inv, DEC_PERM, 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage.valid  <= i_stage.valid;
            r_stage.action <= i_stage.action;
            r_stage.blk    <= (i_stage.action == tbc_pkg::ACT_ENCRYPT) ? w_fwd : w_inv;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: design/tbc_mash_cell.sv
// one mash step cell: key lookup by a byte of the block, xor into the next byte
module tbc_mash_cell #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  tbc_pkg::t_key_wr i_kwr,
    input  tbc_pkg::t_stage  i_stage,
    output tbc_pkg::t_stage  o_stage
);

    localparam logic [1:0] ENC_LANE = 2'(STEP);
    localparam logic [1:0] DEC_LANE = 2'(3 - STEP);

    tbc_pkg::t_stage              r_stage;
    logic [1:0]                   w_in_lane, w_lane;
    logic [7:0]                   w_sel_byte;
    logic [tbc_pkg::RK_AW-1:0]    w_raddr;
    tbc_pkg::t_word               w_rdata;

    // the key index is taken from the byte just below the lane being updated
    assign w_in_lane  = (i_stage.action == tbc_pkg::ACT_ENCRYPT) ? ENC_LANE : DEC_LANE;
    assign w_sel_byte = tbc_pkg::get_byte(i_stage.blk, w_in_lane - 2'd1);
    assign w_raddr    = w_sel_byte[tbc_pkg::RK_AW-1:0];

    tbc_ram #(
        .WIDTH (tbc_pkg::WORD_W),
        .DEPTH (tbc_pkg::NUM_RK)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (i_kwr.en),
        .i_waddr (i_kwr.addr),
        .i_wdata (i_kwr.data),
        .i_re    (i_adv),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage <= i_stage;
        end
    end

    assign w_lane         = (r_stage.action == tbc_pkg::ACT_ENCRYPT) ? ENC_LANE : DEC_LANE;
    assign o_stage.valid  = r_stage.valid;
    assign o_stage.action = r_stage.action;
    assign o_stage.blk    = tbc_pkg::put_byte(r_stage.blk, w_lane,
                                tbc_pkg::get_byte(r_stage.blk, w_lane)
                                ^ tbc_pkg::get_byte(w_rdata, w_lane));

endmodule

FILE: design/toy_block_cipher_32.sv
// top level of the 32-bit toy block cipher: round and mash cell chain with output skid
//
//  channel   direction  handshake              payload
//  input     in         i_valid / o_ready      i_action, i_data_block
//  result    out        o_valid / i_ready      o_result_block
//  key       in         i_cipher_key_we        i_cipher_key (64 bits)
//
// one block per cycle through 16 round cells and 12 mash step cells while nothing stalls; a
// result passes through every cell register and then the skid head before it shows on o_valid
// after reset and after each key write the schedule ring runs its load, forward, backward
// and copying (into the mash memories) states in that order, o_ready low
// the whole chain holds when the two-entry output skid is full and the last cell has data
module toy_block_cipher_32 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [31:0] i_data_block,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_block,
    input  logic        i_cipher_key_we,
    input  logic [63:0] i_cipher_key
);

    localparam int NR = tbc_pkg::NUM_ROUNDS;
    localparam int GR = tbc_pkg::GROUP_ROUNDS;
    localparam int NM = tbc_pkg::NUM_MASH;
    localparam int MS = tbc_pkg::MASH_STEPS;
    localparam int NK = tbc_pkg::NUM_RK;

    logic               w_ks_ready;
    tbc_pkg::t_key_wr   w_kwr;
    tbc_pkg::t_key_bank w_rk;
    logic               w_adv;
    tbc_pkg::t_stage    w_in;
    tbc_pkg::t_stage    w_rnd_in [NR];
    tbc_pkg::t_stage    w_rnd    [NR];
    tbc_pkg::t_stage    w_msh_in [NM][MS];
    tbc_pkg::t_stage    w_msh    [NM][MS];
    tbc_pkg::t_stage    w_last;

    logic               r_hv, n_hv;
    logic               r_sv, n_sv;
    tbc_pkg::t_word     r_hb, n_hb;
    tbc_pkg::t_word     r_sb, n_sb;
    logic               w_push, w_pop;

    tbc_key_sched u_ks (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_we     (i_cipher_key_we),
        .i_key        (i_cipher_key),
        .o_ready      (w_ks_ready),
        .o_kwr        (w_kwr),
        .o_round_keys (w_rk)
    );

    // chain moves unless the skid is full and the last cell holds a result
    assign w_adv   = !r_sv || !w_last.valid;
    assign o_ready = w_ks_ready && w_adv;

    assign w_in.valid  = i_valid && o_ready;
    assign w_in.action = tbc_pkg::t_action'(i_action);
    assign w_in.blk    = i_data_block;

    for (genvar p = 0; p < NR; p++) begin : g_rnd
        if (p == 0) begin : g_first
            assign w_rnd_in[p] = w_in;
        end else if (p % GR == 0) begin : g_after_mash
            assign w_rnd_in[p] = w_msh[p/GR-1][MS-1];
        end else begin : g_after_round
            assign w_rnd_in[p] = w_rnd[p-1];
        end

        tbc_round_cell #(
            .POS (p)
        ) u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_stage  (w_rnd_in[p]),
            .i_ka_enc (w_rk[p]),
            .i_kb_enc (w_rk[NK-1-p]),
            .i_ka_dec (w_rk[NR-1-p]),
            .i_kb_dec (w_rk[NR+p]),
            .o_stage  (w_rnd[p])
        );
    end

    for (genvar g = 0; g < NM; g++) begin : g_msh
        for (genvar s = 0; s < MS; s++) begin : g_step
            if (s == 0) begin : g_first
                assign w_msh_in[g][s] = w_rnd[GR*g+GR-1];
            end else begin : g_next
                assign w_msh_in[g][s] = w_msh[g][s-1];
            end

            tbc_mash_cell #(
                .STEP (s)
            ) u_mash (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_kwr   (w_kwr),
                .i_stage (w_msh_in[g][s]),
                .o_stage (w_msh[g][s])
            );
        end
    end

    assign w_last = w_rnd[NR-1];

    // two-entry output skid: head drives the port, second catches one more transaction
    assign w_push = w_adv && w_last.valid;
    assign w_pop  = r_hv && i_ready;

    always_comb begin
        n_hv = r_hv;
        n_hb = r_hb;
        n_sv = r_sv;
        n_sb = r_sb;
        if (w_pop) begin
            n_hv = r_sv;
            n_hb = r_sb;
            n_sv = 1'b0;
        end
        if (w_push) begin
            if (!n_hv) begin
                n_hv = 1'b1;
                n_hb = w_last.blk;
            end else begin
                n_sv = 1'b1;
                n_sb = w_last.blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_hv <= n_hv;
            r_sv <= n_sv;
        end
        r_hb <= n_hb;
        r_sb <= n_sb;
    end

    assign o_valid        = r_hv;
    assign o_result_block = r_hb;

`ifndef SYNTHESIS
    a_key_write_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_cipher_key_we |=> !o_ready
    ) else $error("input taken right after a key write");

    a_skid_order: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_hv
    ) else $error("skid second entry held without a head entry");

    a_result_leaves_only_when_taken: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_valid) && $past(i_rst_n)) |-> $past(i_ready)
    ) else $error("result dropped without a transaction");

    a_stall_holds_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && $past(i_rst_n)) |=> ($stable(w_last.blk) || !$past(i_rst_n))
    ) else $error("last cell changed during a stall");
`endif

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for toy_block_cipher_32: directed table, then random blocks per key
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = 60;
    localparam int N_DIRECTED   = 25;
    localparam int N_PHASES     = 8;
    localparam int PHASE_BLOCKS = 180;
    localparam int LOG_DEPTH    = 64;
    localparam int TIMEOUT_NS   = 4_000_000;

    localparam logic [0:31][31:0] KEY_TABLE = {
        32'h6a09e667, 32'hbb67ae84, 32'h3c6ef372, 32'ha54ff539,
        32'h510e527f, 32'h9b05688b, 32'h1f83d9ab, 32'h5be0cd18,
        32'hcbbb9d5c, 32'h629a2929, 32'h91590159, 32'h152fecd8,
        32'h67332667, 32'h8eb44a86, 32'hdb0c2e0c, 32'h47b5481d,
        32'hae5f9156, 32'hcf6c85d2, 32'h2f73477d, 32'h6d1826ca,
        32'h8b43d456, 32'he360b595, 32'h1c456002, 32'h6f196330,
        32'hd94ebeb0, 32'h0cc4a611, 32'h261dc1f2, 32'h5815a7bd,
        32'h70b7ed67, 32'ha1513c68, 32'h44f93635, 32'h720dcdfd
    };

    localparam logic [0:3][2:0] LANE_ROT = {3'd2, 3'd3, 3'd5, 3'd7};

    typedef enum logic {
        ROW_BLOCK,
        ROW_KEY
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        tbc_pkg::t_action act;
        tbc_pkg::t_word   blk;
        logic [63:0]      key;
    } t_vector_row;

    typedef struct packed {
        tbc_pkg::t_action act;
        tbc_pkg::t_word   din;
        tbc_pkg::t_word   dout;
    } t_block_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = 1'b0;
    logic [31:0] i_data_block = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result_block;
    logic        i_cipher_key_we = 1'b0;
    logic [63:0] i_cipher_key = '0;

    tbc_pkg::t_word sched_keys [32];
    tbc_pkg::t_word expected_blocks [$];
    t_block_rec     block_log [$];
    int             mismatches = 0;
    int             feed_mode = 1;
    int             sink_mode = 1;

    t_vector_row directed_rows [N_DIRECTED] = '{
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'h00000000, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'h00000000, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'hffffffff, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'hffffffff, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'h00000001, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'h80000000, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'h55555555, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'haaaaaaaa, 64'h0},
        '{ROW_KEY,   tbc_pkg::ACT_ENCRYPT, 32'h00000000, 64'hffffffff_ffffffff},
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'h00000000, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'hffffffff, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'h0f0f0f0f, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'hf0f0f0f0, 64'h0},
        '{ROW_KEY,   tbc_pkg::ACT_ENCRYPT, 32'h00000000, 64'h00000000_ffffffff},
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'h12345678, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'h12345678, 64'h0},
        '{ROW_KEY,   tbc_pkg::ACT_ENCRYPT, 32'h00000000, 64'hffffffff_00000000},
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'h00000000, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'h00000000, 64'h0},
        '{ROW_KEY,   tbc_pkg::ACT_ENCRYPT, 32'h00000000, 64'h01234567_89abcdef},
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'h0000ffff, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'hffff0000, 64'h0},
        '{ROW_KEY,   tbc_pkg::ACT_ENCRYPT, 32'h00000000, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_ENCRYPT, 32'h00000000, 64'h0},
        '{ROW_BLOCK, tbc_pkg::ACT_DECRYPT, 32'hdeadbeef, 64'h0}
    };

    toy_block_cipher_32 uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_data_block    (i_data_block),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_block  (o_result_block),
        .i_cipher_key_we (i_cipher_key_we),
        .i_cipher_key    (i_cipher_key)
    );

    always #5 i_clk = ~i_clk;

    // round key schedule: forward pass then backward pass through the constant table
    function automatic void load_schedule(input logic [63:0] key);
        tbc_pkg::t_word sel;
        sched_keys[0] = key[31:0];
        sched_keys[1] = key[63:32];
        for (int i = 2; i < 32; i++) begin
            sel = sched_keys[i-1] ^ sched_keys[i-2];
            sched_keys[i] = KEY_TABLE[sel[4:0]] ^ sched_keys[i-1];
        end
        for (int i = 29; i >= 0; i--) begin
            sel = sched_keys[i+1] ^ sched_keys[i+2];
            sched_keys[i] = sched_keys[i] ^ KEY_TABLE[sel[4:0]];
        end
    endfunction

    function automatic logic [7:0] lane(input tbc_pkg::t_word x, input int i);
        return x[8*(i%4) +: 8];
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] ror8(input logic [7:0] x, input int n);
        return (x >> n) | (x << (8 - n));
    endfunction

    function automatic tbc_pkg::t_word bit_rev(input tbc_pkg::t_word x);
        tbc_pkg::t_word r;
        for (int i = 0; i < 32; i++) r[i] = x[31-i];
        return r;
    endfunction

    // chunks of the upper half land on odd slots, lower half on even slots
    function automatic tbc_pkg::t_word weave(input tbc_pkg::t_word x, input int w,
                                             input bit undo);
        tbc_pkg::t_word r;
        tbc_pkg::t_word m;
        r = '0;
        m = (32'd1 << w) - 32'd1;
        for (int k = 0; k < 16 / w; k++) begin
            if (!undo) begin
                r |= ((x >> (16 + k*w)) & m) << ((2*k + 1) * w);
                r |= ((x >> (k*w)) & m) << (2*k*w);
            end else begin
                r |= ((x >> ((2*k + 1) * w)) & m) << (16 + k*w);
                r |= ((x >> (2*k*w)) & m) << (k*w);
            end
        end
        return r;
    endfunction

    function automatic tbc_pkg::t_word round_perm(input tbc_pkg::t_word x, input int j,
                                                  input bit undo);
        case (j % 4)
            1: return weave(x, 1, undo);
            2: return weave(x, 4, undo);
            default: return bit_rev(x);
        endcase
    endfunction

    function automatic logic [7:0] lane_mix(input tbc_pkg::t_word b, input int i,
                                            input tbc_pkg::t_word ka,
                                            input tbc_pkg::t_word kb);
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] r;
        p = lane(b, i + 3);
        q = lane(b, i + 2);
        r = lane(b, i + 1);
        return (p & q) ^ (~p & r) ^ lane(ka, i) ^ lane(kb, i);
    endfunction

    function automatic tbc_pkg::t_word mash_lane(input tbc_pkg::t_word b, input int i);
        logic [7:0]     sel;
        tbc_pkg::t_word k;
        sel = lane(b, i + 3);
        k = sched_keys[sel[4:0]];
        b[8*i +: 8] = lane(b, i) ^ lane(k, i);
        return b;
    endfunction

    function automatic tbc_pkg::t_word cipher_transform(input tbc_pkg::t_action act,
                                                        input tbc_pkg::t_word din);
        tbc_pkg::t_word b;
        tbc_pkg::t_word ka;
        tbc_pkg::t_word kb;
        b = din;
        if (act == tbc_pkg::ACT_ENCRYPT) begin
            for (int j = 0; j < 16; j++) begin
                ka = sched_keys[j];
                kb = sched_keys[31-j];
                b = round_perm(b, j, 1'b0);
                for (int i = 0; i < 4; i++)
                    b[8*i +: 8] = rol8(lane(b, i) ^ lane_mix(b, i, ka, kb), LANE_ROT[i]);
                if (j % 4 == 3 && j != 15)
                    for (int i = 0; i < 4; i++) b = mash_lane(b, i);
            end
        end else begin
            for (int j = 15; j >= 0; j--) begin
                ka = sched_keys[j];
                kb = sched_keys[31-j];
                for (int i = 3; i >= 0; i--)
                    b[8*i +: 8] = ror8(lane(b, i), LANE_ROT[i]) ^ lane_mix(b, i, ka, kb);
                b = round_perm(b, j, 1'b1);
                if (j % 4 == 0 && j != 0)
                    for (int i = 3; i >= 0; i--) b = mash_lane(b, i);
            end
        end
        return b;
    endfunction

    // idle styles: 0 back to back, 1 uniform waits, 2 mostly back to back with bursts
    function automatic int draw_wait(input int style);
        case (style)
            0: return 0;
            1: return $urandom_range(0, MAX_WAIT);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_block(input tbc_pkg::t_action act, input tbc_pkg::t_word din);
        int             gap;
        tbc_pkg::t_word dout;
        if ($urandom_range(0, 63) == 0) feed_mode = $urandom_range(0, 2);
        gap = draw_wait(feed_mode);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_data_block <= din;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        dout = cipher_transform(act, din);
        expected_blocks.push_back(dout);
        block_log.push_back('{act, din, dout});
        if (block_log.size() > LOG_DEPTH) void'(block_log.pop_front());
    endtask

    // key changes only with the pipe empty
    task automatic write_key(input logic [63:0] key);
        i_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        i_cipher_key_we <= 1'b1;
        i_cipher_key    <= key;
        @(posedge i_clk);
        i_cipher_key_we <= 1'b0;
        load_schedule(key);
        block_log.delete();
    endtask

    initial begin : result_sink
        int             stall;
        tbc_pkg::t_word want;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) sink_mode = $urandom_range(0, 2);
            stall = draw_wait(sink_mode);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (expected_blocks.size() == 0) begin
                mismatches++;
                $display("%0t: result %08h with nothing expected", $time, o_result_block);
            end else begin
                want = expected_blocks.pop_front();
                if (o_result_block !== want) begin
                    mismatches++;
                    $display("%0t: result_block expected %08h, got %08h",
                             $time, want, o_result_block);
                end
            end
        end
    end

    initial begin : block_feed
        int               sel;
        int               pick;
        logic [63:0]      phase_key;
        t_block_rec       rec;
        tbc_pkg::t_word   din;
        tbc_pkg::t_action act;

        load_schedule(64'h0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_KEY)
                write_key(directed_rows[r].key);
            else
                send_block(directed_rows[r].act, directed_rows[r].blk);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                1: phase_key = 64'h80000000_00000001;
                3: phase_key = 64'hffffffff_ffffffff;
                5: phase_key = 64'h0;
                7: phase_key = 64'h55555555_aaaaaaaa;
                default: phase_key = {$urandom, $urandom};
            endcase
            write_key(phase_key);
            for (int n = 0; n < PHASE_BLOCKS; n++) begin
                sel = $urandom_range(0, 99);
                act = tbc_pkg::t_action'($urandom_range(0, 1));
                if (sel < 35 && block_log.size() > 0) begin
                    // undo an earlier transaction: decrypt a ciphertext or re-encrypt a plaintext
                    rec = block_log[$urandom_range(0, block_log.size() - 1)];
                    act = (rec.act == tbc_pkg::ACT_ENCRYPT) ? tbc_pkg::ACT_DECRYPT
                                                            : tbc_pkg::ACT_ENCRYPT;
                    din = rec.dout;
                end else if (sel < 50) begin
                    pick = $urandom_range(0, 4);
                    case (pick)
                        0: din = 32'h0;
                        1: din = 32'hffffffff;
                        2: din = 32'h1 << $urandom_range(0, 31);
                        3: din = ~(32'h1 << $urandom_range(0, 31));
                        default: din = {4{8'($urandom)}};
                    endcase
                end else begin
                    din = $urandom;
                end
                send_block(act, din);
            end
        end

        i_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
